FILE: hw/rtl/bhm_pkg.sv
// bhm_pkg: shared types and constants for the bounded key-value table.
// Used by bhm_cell, bhm_group and bounded_hash_map_evict_oldest.
// No dependencies.
package bhm_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_PUT = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] lookup_key;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_PULL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     probe;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_APPLY
    } state_t;

endpackage

FILE: hw/rtl/bhm_cell.sv
// bhm_cell: one slot of the age-ordered entry chain.
// Holds valid/key/value, loads from either neighbor, registers a key match.
// Depends on bhm_pkg.
module bhm_cell
    import bhm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  entry_t              left,
    input  entry_t              right,
    input  logic [KEY_BITS-1:0] probe_key,
    output entry_t              q,
    output logic                match
);

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  match_reg, match_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        case (ctrl.op)
            CELL_SHIFT:
            begin
                valid_next = left.valid;
                key_next   = left.key;
                value_next = left.value;
            end
            CELL_PULL:
            begin
                valid_next = right.valid;
                key_next   = right.key;
                value_next = right.value;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
        match_next = ctrl.probe ? (valid_reg && (key_reg == probe_key)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign q.valid = valid_reg;
    assign q.key   = key_reg;
    assign q.value = value_reg;
    assign match   = match_reg;

endmodule

FILE: hw/rtl/bhm_group.sv
// bhm_group: registered reduction over one group of cells.
// Produces in-group match prefix, group hit and the matching value.
// Depends on bhm_pkg.
module bhm_group
    import bhm_pkg::*;
(
    input  logic                                  clk,
    input  logic [GROUP_SIZE-1:0]                 match,
    input  logic [GROUP_SIZE-1:0][VALUE_BITS-1:0] values,
    output logic                                  any,
    output logic [GROUP_SIZE-1:0]                 prefix,
    output logic [VALUE_BITS-1:0]                 sel_value
);

    logic                  any_reg, any_next;
    logic [GROUP_SIZE-1:0] prefix_reg, prefix_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    always_comb
    begin
        logic run;
        run        = 1'b0;
        value_next = '0;
        for (int j = 0; j < GROUP_SIZE; j++)
        begin
            run            = run | match[j];
            prefix_next[j] = run;
            // keys are unique, so at most one value survives the mask
            value_next     = value_next | (match[j] ? values[j] : '0);
        end
        any_next = run;
    end

    always_ff @(posedge clk)
    begin
        any_reg    <= any_next;
        prefix_reg <= prefix_next;
        value_reg  <= value_next;
    end

    assign any       = any_reg;
    assign prefix    = prefix_reg;
    assign sel_value = value_reg;

endmodule

FILE: hw/rtl/bounded_hash_map_evict_oldest.sv
// bounded_hash_map_evict_oldest: bounded key-value table, oldest write evicted.
// Top level: sequencer, row of bhm_cell, bhm_group reduction, result register.
// Depends on bhm_pkg, bhm_cell, bhm_group.
//
//  channel | valid     | stall     | payload      | beat
//  request | req_valid | req_stall | req (req_t)  | command, lookup_key, write_value
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)  | hit, read_value, evicted
//
// Each request goes through accept, compare in every cell, group
// reduction, then apply the chain move and load the result register.
// Entries sit newest first in the cell row; the last valid cell is the oldest.
// Reset empties the table at once (valid bits only), no clearing pass.
// A waiting result holds the apply step; no new request is taken meanwhile.
module bounded_hash_map_evict_oldest
    import bhm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    entry_t                                cell_q [CAPACITY];
    cell_ctrl_t                            cell_ctrl [CAPACITY];
    logic [PAD_CELLS-1:0]                  match_vec;
    logic [PAD_CELLS-1:0][VALUE_BITS-1:0]  cell_val;
    logic [NUM_GROUPS-1:0]                 grp_any;
    logic [PAD_CELLS-1:0]                  grp_pre;
    logic [VALUE_BITS-1:0]                 grp_val [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]                 grp_before;
    logic [CAPACITY-1:0]                   pre_incl;
    logic [CAPACITY-1:0]                   valid_vec;
    logic [CAPACITY-1:0]                   fill_mask;

    entry_t              new_entry;
    entry_t              empty_entry;
    logic [KEY_BITS-1:0] probe_key;
    logic                go;
    logic                hit_any;
    logic                full;
    logic                is_get, is_put, is_del;
    logic [VALUE_BITS-1:0] hit_value;

    assign probe_key         = req_reg.lookup_key[KEY_BITS-1:0];
    assign new_entry.valid   = 1'b1;
    assign new_entry.key     = probe_key;
    assign new_entry.value   = VALUE_BITS'(req_reg.write_value);
    assign empty_entry       = '0;

    assign is_get  = req_reg.command == CMD_GET;
    assign is_put  = req_reg.command == CMD_PUT;
    assign is_del  = req_reg.command == CMD_DEL;
    assign full    = count_reg == CNT_W'(CAPACITY);
    assign hit_any = |grp_any;
    assign go      = (state_reg == ST_APPLY) && (!rsp_valid_reg || !rsp_stall);

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bhm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .left      ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i - 1]),
            .right     ((i == CAPACITY - 1) ? empty_entry
                                            : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
            .probe_key (probe_key),
            .q         (cell_q[i]),
            .match     (match_vec[i])
        );
        assign cell_val[i]  = cell_q[i].value;
        assign valid_vec[i] = cell_q[i].valid;

        always_comb
        begin
            logic shift_en;
            if (i == 0)
                shift_en = 1'b1;
            else if (hit_any)
                shift_en = !pre_incl[(i == 0) ? 0 : i - 1];
            else
                shift_en = CNT_W'(i) <= count_reg;

            cell_ctrl[i].probe = state_reg == ST_CMP;
            cell_ctrl[i].op    = CELL_HOLD;
            if (go && is_put && shift_en)
                cell_ctrl[i].op = CELL_SHIFT;
            else if (go && is_del && pre_incl[i])
                cell_ctrl[i].op = CELL_PULL;
        end
    end

    for (genvar i = CAPACITY; i < PAD_CELLS; i++)
    begin : g_pad
        assign match_vec[i] = 1'b0;
        assign cell_val[i]  = '0;
    end

    // group reduction
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        bhm_group u_group (
            .clk       (clk),
            .match     (match_vec[g*GROUP_SIZE +: GROUP_SIZE]),
            .values    (cell_val[g*GROUP_SIZE +: GROUP_SIZE]),
            .any       (grp_any[g]),
            .prefix    (grp_pre[g*GROUP_SIZE +: GROUP_SIZE]),
            .sel_value (grp_val[g])
        );
    end

    always_comb
    begin
        grp_before[0] = 1'b0;
        for (int g = 1; g < NUM_GROUPS; g++)
        begin
            grp_before[g] = grp_before[g-1] | grp_any[g-1];
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            pre_incl[i]  = grp_pre[i] | grp_before[i / GROUP_SIZE];
            fill_mask[i] = CNT_W'(i) < count_reg;
        end
        hit_value = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            hit_value = hit_value | grp_val[g];
        end
    end

    // sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        req_stall      = state_reg != ST_IDLE;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_GRP;
            end
            ST_GRP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (go)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit        = hit_any && (is_get || is_put || is_del);
                    rsp_next.read_value = (is_get && hit_any) ? 32'(hit_value) : 32'd0;
                    rsp_next.evicted    = is_put && !hit_any && full;
                    if (is_put && !hit_any && !full)
                        count_next = count_reg + CNT_W'(1);
                    else if (is_del && hit_any)
                        count_next = count_reg - CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec == fill_mask)
        else $error("valid cells not packed at the head of the row");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted |-> full)
        else $error("eviction reported while table not full");

    a_apply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_APPLY && rsp_valid_reg && rsp_stall |=> $stable(count_reg))
        else $error("table changed while result beat was stalled");

endmodule
